FILE: sv/tdps_pkg.sv
// Shared types, constants and command/status structs for the divider pair search
`timescale 1ns / 1ps
`default_nettype none
package tdps_pkg;
   localparam int unsigned CountLimit = 65535;
   localparam logic [15:0] HI_LIMIT = 16'(CountLimit - 1);
   localparam logic [31:0] CLOCK_RESET = 32'd84000000;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_BAD   = 2'd1;
   localparam logic [1:0] STATUS_NONE  = 2'd2;

   // controller to datapath
   typedef struct packed {
      logic load;       // capture request, start quotient division
      logic div_step;   // one restoring division step
      logic sqrt_init;
      logic sqrt_step;
      logic psc_init;   // psc = isqrt result, start q / psc
      logic cand_eval;  // evaluate both candidates for the current psc
      logic psc_dec;
      logic ach_init;   // start clock / (arr * psc)
      logic fin;        // latch result word
   } tdps_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic bad_req;
      logic div_done;
      logic sqrt_done;
      logic psc_live;    // psc > 1
      logic psc_skip;    // psc above the period limit
      logic exact;       // last accepted candidate hit zero error
   } tdps_sts_type;
endpackage
`default_nettype wire

FILE: sv/tdps_datapath.sv
// Datapath: shared serial divider, serial square root and candidate compare
`timescale 1ns / 1ps
`default_nettype none
module tdps_datapath
   import tdps_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic [31:0]  clk_hz,
   input  wire logic [31:0]  freq_in,
   input  wire tdps_cmd_type cmd,
   output tdps_sts_type      sts,
   output logic [15:0]       period_out,
   output logic [15:0]       prescale_out,
   output logic [32:0]       error_out,
   output logic [1:0]        status_out
);
   logic [31:0] freq_ff, freq_in_d;
   logic [31:0] q_ff;
   // serial divider: 32-bit dividend, 32-bit divisor
   logic [31:0] dvd_ff, dvd_in, dvs_ff, dvs_in;
   logic [32:0] rem_ff, rem_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [1:0]  dsel_ff, dsel_in; // 0 quotient, 1 q/psc, 2 achieved
   // isqrt
   logic [31:0] sv_ff, sv_in, sres_ff, sres_in, sbit_ff, sbit_in;
   logic [15:0] psc_ff, psc_in;
   logic [15:0] barr_ff, barr_in, bpsc_ff, bpsc_in;
   logic [32:0] berr_ff, berr_in;
   logic        found_ff, found_in, exact_ff, exact_in;
   logic [15:0] po_ff, po_in, pso_ff, pso_in;
   logic [32:0] eo_ff, eo_in;
   logic [1:0]  so_ff, so_in;

   logic [32:0] trial;
   logic [31:0] f_c, f1_c;
   logic [15:0] c1, c2, arr_c;
   logic [32:0] p1, p2, e1, e2, err_c;
   logic        bad_c;

   assign freq_in_d = freq_in;
   assign bad_c = (freq_ff == 32'd0) || (freq_ff > clk_hz);
   assign trial = {rem_ff[31:0], dvd_ff[31]} - {1'b0, dvs_ff};

   always_comb begin
      f_c  = dvd_ff;
      f1_c = dvd_ff + 32'd1;
      c1 = (f_c < {16'd0, psc_ff}) ? psc_ff :
           (f_c > {16'd0, HI_LIMIT}) ? HI_LIMIT : f_c[15:0];
      c2 = (f1_c < {16'd0, psc_ff}) ? psc_ff :
           ((f1_c > {16'd0, HI_LIMIT}) || (f1_c == 32'd0)) ? HI_LIMIT : f1_c[15:0];
      p1 = 33'(c1) * 33'(psc_ff);
      p2 = 33'(c2) * 33'(psc_ff);
      e1 = (p1 > {1'b0, q_ff}) ? p1 - {1'b0, q_ff} : {1'b0, q_ff} - p1;
      e2 = (p2 > {1'b0, q_ff}) ? p2 - {1'b0, q_ff} : {1'b0, q_ff} - p2;
      if (e2 < e1 || (e2 == e1 && c2 < c1)) begin
         arr_c = c2; err_c = e2;
      end else begin
         arr_c = c1; err_c = e1;
      end
   end

   always_comb begin
      dvd_in = dvd_ff; dvs_in = dvs_ff; rem_in = rem_ff; cnt_in = cnt_ff;
      dsel_in = dsel_ff;
      sv_in = sv_ff; sres_in = sres_ff; sbit_in = sbit_ff; psc_in = psc_ff;
      barr_in = barr_ff; bpsc_in = bpsc_ff; berr_in = berr_ff;
      found_in = found_ff; exact_in = exact_ff;
      po_in = po_ff; pso_in = pso_ff; eo_in = eo_ff; so_in = so_ff;
      if (cmd.load) begin
         dvd_in = clk_hz; dvs_in = freq_in_d; rem_in = '0; cnt_in = 6'd32;
         dsel_in = 2'd0; found_in = 1'b0; exact_in = 1'b0;
      end
      if (cmd.div_step) begin
         if (!trial[32]) begin
            rem_in = trial;
            dvd_in = {dvd_ff[30:0], 1'b1};
         end else begin
            rem_in = {rem_ff[31:0], dvd_ff[31]};
            dvd_in = {dvd_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
      end
      if (cmd.sqrt_init) begin
         sv_in = dvd_ff; sres_in = '0; sbit_in = 32'h4000_0000;
      end
      // while the bit is still above the value the result stays zero, so one
      // step rule covers both the bit search and the root digits
      if (cmd.sqrt_step) begin
         if (sv_ff >= sres_ff + sbit_ff) begin
            sv_in = sv_ff - (sres_ff + sbit_ff);
            sres_in = (sres_ff >> 1) + sbit_ff;
            sbit_in = sbit_ff >> 2;
         end else begin
            sres_in = sres_ff >> 1;
            sbit_in = sbit_ff >> 2;
         end
      end
      if (cmd.psc_init) psc_in = sres_ff[15:0];
      if (cmd.psc_dec)  psc_in = psc_ff - 16'd1;
      if (cmd.psc_init || cmd.psc_dec) begin
         dvd_in = q_ff; dvs_in = {16'd0, cmd.psc_dec ? psc_ff - 16'd1 : sres_ff[15:0]};
         rem_in = '0; cnt_in = 6'd32; dsel_in = 2'd1;
      end
      if (cmd.cand_eval && (!found_ff || err_c < berr_ff)) begin
         found_in = 1'b1; berr_in = err_c; barr_in = arr_c; bpsc_in = psc_ff;
         exact_in = (err_c == 33'd0);
      end
      if (cmd.ach_init) begin
         dvd_in = clk_hz; dvs_in = 32'(barr_ff) * 32'(bpsc_ff); rem_in = '0;
         cnt_in = 6'd32; dsel_in = 2'd2;
      end
      if (cmd.fin) begin
         if (bad_c) begin
            po_in = '0; pso_in = '0; so_in = STATUS_BAD;
            eo_in = {1'b0, freq_ff} - {1'b0, clk_hz};
         end else if (!found_ff) begin
            po_in = '0; pso_in = '0; so_in = STATUS_NONE; eo_in = '0;
         end else begin
            po_in = barr_ff; pso_in = bpsc_ff; so_in = STATUS_OK;
            eo_in = {1'b0, freq_ff} - {1'b0, dvd_ff};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) freq_ff <= freq_in;
      if (cmd.div_step && cnt_ff == 6'd1 && dsel_ff == 2'd0)
         q_ff <= trial[32] ? {dvd_ff[30:0], 1'b0} : {dvd_ff[30:0], 1'b1};
      dvd_ff <= dvd_in; dvs_ff <= dvs_in; rem_ff <= rem_in;
      sv_ff <= sv_in; sres_ff <= sres_in; sbit_ff <= sbit_in; psc_ff <= psc_in;
      barr_ff <= barr_in; bpsc_ff <= bpsc_in; berr_ff <= berr_in;
      po_ff <= po_in; pso_ff <= pso_in; eo_ff <= eo_in; so_ff <= so_in;
      if (reset) begin
         cnt_ff <= '0; dsel_ff <= '0; found_ff <= 1'b0; exact_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in; dsel_ff <= dsel_in; found_ff <= found_in; exact_ff <= exact_in;
      end
   end

   assign sts.bad_req   = bad_c;
   assign sts.div_done  = (cnt_ff == 6'd0);
   assign sts.sqrt_done = (sbit_ff == 32'd0);
   assign sts.psc_live  = (psc_ff > 16'd1);
   assign sts.psc_skip  = (psc_ff > HI_LIMIT);
   assign sts.exact     = exact_ff;
   assign period_out   = po_ff;
   assign prescale_out = pso_ff;
   assign error_out    = eo_ff;
   assign status_out   = so_ff;
endmodule
`default_nettype wire

FILE: sv/tdps_ctrl.sv
// Controller: sequences division, square root and the prescaler sweep
`timescale 1ns / 1ps
`default_nettype none
module tdps_ctrl
   import tdps_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   input  wire tdps_sts_type sts,
   output tdps_cmd_type      cmd,
   output logic              busy,
   output logic              done
);
   localparam logic [3:0] S_IDLE = 4'd0, S_CHK = 4'd1, S_QDIV = 4'd2, S_SQI = 4'd3,
                          S_SQ = 4'd4, S_PSC = 4'd5, S_PDIV = 4'd6, S_EVAL = 4'd7,
                          S_NEXT = 4'd8, S_ADIV = 4'd9, S_FIN = 4'd10, S_DONE = 4'd11,
                          S_ACH = 4'd12;
   logic [3:0] state_ff, state_in;

   always_comb begin
      cmd = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (start) begin cmd.load = 1'b1; state_in = S_CHK; end
         S_CHK:  state_in = sts.bad_req ? S_FIN : S_QDIV;
         S_QDIV: if (sts.div_done) state_in = S_SQI; else cmd.div_step = 1'b1;
         S_SQI:  begin cmd.sqrt_init = 1'b1; state_in = S_SQ; end
         S_SQ:   if (sts.sqrt_done) begin cmd.psc_init = 1'b1; state_in = S_PSC; end
                 else cmd.sqrt_step = 1'b1;
         S_PSC: begin
            if (!sts.psc_live) state_in = S_ACH;
            else if (sts.psc_skip) begin cmd.psc_dec = 1'b1; state_in = S_PSC; end
            else state_in = S_PDIV;
         end
         S_PDIV: if (sts.div_done) state_in = S_EVAL; else cmd.div_step = 1'b1;
         S_EVAL: begin cmd.cand_eval = 1'b1; state_in = S_NEXT; end
         S_NEXT: if (sts.exact) state_in = S_ACH;
                 else begin cmd.psc_dec = 1'b1; state_in = S_PSC; end
         S_ACH:  begin cmd.ach_init = 1'b1; state_in = S_ADIV; end
         S_ADIV: if (sts.div_done) state_in = S_FIN; else cmd.div_step = 1'b1;
         S_FIN:  begin cmd.fin = 1'b1; state_in = S_DONE; end
         S_DONE: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

   assign busy = (state_ff != S_IDLE);
   assign done = (state_ff == S_DONE);

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> state_ff == S_IDLE) else $error("load outside idle");
   a_fin_done: assert property (@(posedge clock) disable iff (reset)
      cmd.fin |=> done) else $error("finish not followed by done");
   a_one_step: assert property (@(posedge clock) disable iff (reset)
      !(cmd.div_step && cmd.sqrt_step)) else $error("two units stepped");
endmodule
`default_nettype wire

FILE: sv/timer_divider_pair_search_unit.sv
// Top level: stream wrapper around the divider pair search controller and datapath
//
// req_ channel carries one wanted frequency word (tdata[31:0]); rsp_ returns
// one result word per request. csr_wr_en/csr_wr_data load the timer clock.
// An item runs the quotient division and the square root, then for each
// prescaler tried one 32-step serial divide, its check, compare and step;
// a prescaler above the period limit is skipped with a step only. The
// achieved-frequency divide and the finish follow; the shared serial
// divider sets the worst case.
// A bad request skips the divisions and goes straight to the finish.
// One item is processed at a time; req_tready is low while busy. The result
// sits in an output register; a new request is taken while it waits. If the
// output is full when the search finishes, the word waits in a second stage until it is free.
// Reset clears control state and loads 84 MHz into the clock register.
`timescale 1ns / 1ps
`default_nettype none
module timer_divider_pair_search_unit
   import tdps_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // [31:0] wanted_freq_hz
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [71:0]      rsp_tdata,   // [15:0] period_count, [31:16] prescale_count,
                                         // [64:32] freq_error_hz, [66:65] search_status
   input  wire logic        csr_wr_en,
   input  wire logic [31:0] csr_wr_data
);
   logic [31:0] clk_hz_ff;
   logic        rv_ff;
   logic [71:0] rd_ff;
   logic        hold_ff;
   tdps_cmd_type cmd;
   tdps_sts_type sts;
   logic busy, done, start;
   logic [15:0] po, pso;
   logic [32:0] eo;
   logic [1:0]  so;

   // a finished word waits in hold_ff when the output register is still full
   assign req_tready = !busy && !hold_ff;
   assign start = req_tvalid && req_tready;

   tdps_ctrl u_ctrl (.clock, .reset, .start, .sts, .cmd, .busy, .done);
   tdps_datapath u_dp (.clock, .reset, .clk_hz(clk_hz_ff), .freq_in(req_tdata),
      .cmd, .sts, .period_out(po), .prescale_out(pso), .error_out(eo), .status_out(so));

   always_ff @(posedge clock) begin
      if (reset) begin
         clk_hz_ff <= CLOCK_RESET; rv_ff <= 1'b0; hold_ff <= 1'b0;
      end else begin
         if (csr_wr_en) clk_hz_ff <= csr_wr_data;
         if (done || hold_ff) begin
            if (!rv_ff || rsp_tready) begin
               rv_ff <= 1'b1; hold_ff <= 1'b0;
               rd_ff <= {5'd0, so, eo, pso, po};
            end else hold_ff <= 1'b1;
         end else if (rsp_tready) begin
            rv_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = rv_ff;
   assign rsp_tdata  = rd_ff;

   a_no_start_busy: assert property (@(posedge clock) disable iff (reset)
      start |=> busy) else $error("request taken but not busy");
   a_hold_full: assert property (@(posedge clock) disable iff (reset)
      hold_ff |-> rv_ff) else $error("held word with empty output");
   a_done_not_lost: assert property (@(posedge clock) disable iff (reset)
      (done && rv_ff && !rsp_tready) |=> hold_ff) else $error("word dropped");
endmodule
`default_nettype wire
